@@ rtl/nearest_center_assign_defines.svh @@
// Assertion macros shared by the nearest-center assignment RTL.
`ifndef NEAREST_CENTER_ASSIGN_DEFINES_SVH
`define NEAREST_CENTER_ASSIGN_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define NCA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define NCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define NCA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define NCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/nca_pkg.sv @@
// Package with types, constants and codes of the nearest-center assignment block.
package nca_pkg;

	// Default structural sizes.
	localparam int MAX_CLUSTERS_DEF = 16;
	localparam int MAX_DIMS_DEF     = 16;
	localparam int COORD_BITS_DEF   = 16;

	// Configuration register width and reset values.
	localparam int          CFG_W              = 5;
	localparam logic [4:0]  NUM_CLUSTERS_RESET = 5'd4;
	localparam logic [4:0]  NUM_DIMS_RESET     = 5'd3;

	// Output stream payload width: sample number, nearest cluster, zero fill.
	localparam int SAMPLE_W    = 32;
	localparam int CLUSTER_W   = 4;
	localparam int OUT_TDATA_W = ((SAMPLE_W + CLUSTER_W + 7) / 8) * 8;

	// Register indexes, taken from paddr[2].
	typedef enum logic {
		REG_NUM_CLUSTERS = 1'b0,
		REG_NUM_DIMS     = 1'b1
	} reg_idx_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;   // take the accepted coordinate
		logic issue;  // start one center visit at the given index
		logic emit;   // move the finished sample result to the output register
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic last;         // current coordinate completes its sample
		logic final_visit;  // the given index is the last center in use
		logic busy;         // visits still in flight in the pipeline
		logic out_free;     // output register can take a result this cycle
	} sts_t;

endpackage

@@ rtl/nearest_center_assign.sv @@
// Top level of the streaming nearest-center assignment block.
//
//  Channel  Dir  Handshake            Payload
//  apb      in   psel/penable/pready  paddr, pwdata, prdata (num_clusters, num_dims)
//  s_axis   in   s_tvalid/s_tready    s_tdata: coord_value
//  m_axis   out  m_tvalid/m_tready    m_tdata: sample_number, nearest_cluster; m_tuser
//
// Each coordinate is compared with the active centers, the centers in use; one shared
// unit visits a center per cycle. Coordinates are taken one at a time; a completed
// result waits in the output register while the next coordinate is processed, and a
// sample end stalls only if that register is still full. Reset clears counters and
// accumulators at once; the center store needs no clearing pass.
`include "nearest_center_assign_defines.svh"

module nearest_center_assign import nca_pkg::*; #(
	parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
	parameter int MAX_DIMS     = MAX_DIMS_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration port.
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [2:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	// Input stream.
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// s_tdata: [COORD_BITS-1:0] coord_value, zero fill above
	input  logic [((COORD_BITS + 7) / 8) * 8-1:0] s_tdata,
	// Output stream.
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// m_tdata: [31:0] sample_number, [35:32] nearest_cluster, zero fill above
	output logic [OUT_TDATA_W-1:0]                m_tdata,
	// m_tuser: [0] became_center
	output logic                                  m_tuser
);

	localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

	logic [CFG_W-1:0] num_clusters_q;
	logic [CFG_W-1:0] num_dims_q;
	logic             cfg_write;
	reg_idx_t         cfg_idx;

	cmd_t             cmd;
	sts_t             sts;
	logic [CW-1:0]    cidx;

	logic [SAMPLE_W-1:0]  sample_number;
	logic [CLUSTER_W-1:0] nearest_cluster;
	logic                 became_center;

	// Configuration registers, written in the access phase of a transaction.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_idx   = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clusters_q <= NUM_CLUSTERS_RESET;
			num_dims_q     <= NUM_DIMS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				REG_NUM_CLUSTERS: num_clusters_q <= pwdata[CFG_W-1:0];
				REG_NUM_DIMS:     num_dims_q     <= pwdata[CFG_W-1:0];
				default:          num_dims_q     <= num_dims_q;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (cfg_idx)
			REG_NUM_CLUSTERS: prdata = 32'(num_clusters_q);
			REG_NUM_DIMS:     prdata = 32'(num_dims_q);
			default:          prdata = '0;
		endcase
	end

	nca_ctrl #(
		.MAX_CLUSTERS (MAX_CLUSTERS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.cidx     (cidx),
		.sts      (sts)
	);

	nca_dp #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.MAX_DIMS     (MAX_DIMS),
		.COORD_BITS   (COORD_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.num_clusters    (num_clusters_q),
		.num_dims        (num_dims_q),
		.coord_value     (s_tdata[COORD_BITS-1:0]),
		.cmd             (cmd),
		.cidx            (cidx),
		.sts             (sts),
		.out_ready       (m_tready),
		.out_valid       (m_tvalid),
		.sample_number   (sample_number),
		.nearest_cluster (nearest_cluster),
		.became_center   (became_center)
	);

	// Pack the result payload.
	assign m_tdata = OUT_TDATA_W'({nearest_cluster, sample_number});
	assign m_tuser = became_center;

	// A new coordinate is only taken with the visit pipeline empty.
	`NCA_ASSERT_IMPLY(a_ready_idle, clk, arst_n, s_tready, !sts.busy)
	// A result is never moved into a full output register.
	`NCA_ASSERT_IMPLY(a_emit_free, clk, arst_n, cmd.emit, sts.out_free)
	// Taking a coordinate starts the visits, so the next one waits.
	`NCA_ASSERT_NEXT(a_load_busy, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

@@ rtl/nca_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module nca_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/nca_ctrl.sv @@
// Controller state machine that sequences center visits for each coordinate.
module nca_ctrl import nca_pkg::*; #(
	parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                in_valid,
	output logic                                                in_ready,
	output cmd_t                                                cmd,
	output logic [((MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1)-1:0] cidx,
	input  sts_t                                                sts
);

	localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

	state_t        state_q, state_d;
	logic [CW-1:0] cidx_q, cidx_d;

	// State and visit counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cidx_q  <= '0;
		end else begin
			state_q <= state_d;
			cidx_q  <= cidx_d;
		end
	end

	assign cidx = cidx_q;

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cidx_d    = cidx_q;
		in_ready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cidx_d   = '0;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (sts.final_visit) begin
					state_d = ST_DRAIN;
				end else begin
					cidx_d = cidx_q + CW'(1);
				end
			end
			ST_DRAIN: begin
				if (!sts.busy) begin
					state_d = sts.last ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/nca_dp.sv @@
// Datapath: center store, shared subtract-square-accumulate unit, minimum search.
module nca_dp import nca_pkg::*; #(
	parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
	parameter int MAX_DIMS     = MAX_DIMS_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic [CFG_W-1:0]                                    num_clusters,
	input  logic [CFG_W-1:0]                                    num_dims,
	input  logic [COORD_BITS-1:0]                               coord_value,
	input  cmd_t                                                cmd,
	input  logic [((MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1)-1:0] cidx,
	output sts_t                                                sts,
	input  logic                                                out_ready,
	output logic                                                out_valid,
	output logic [SAMPLE_W-1:0]                                 sample_number,
	output logic [CLUSTER_W-1:0]                                nearest_cluster,
	output logic                                                became_center
);

	localparam int CW       = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int LW       = $clog2(MAX_CLUSTERS + 1);
	localparam int DW       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DEPTH    = MAX_CLUSTERS * MAX_DIMS;
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SQ_W     = 2 * (COORD_BITS + 1);
	localparam int ACC_FULL = SQ_W + DW;
	localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;

	// Item registers.
	logic [COORD_BITS-1:0] x_q;
	logic [DW-1:0]         d_q;
	logic                  last_q;
	logic                  becoming_q;
	logic [LW-1:0]         active_q;

	// Running counters.
	logic [DW-1:0]         coord_cnt_q;
	logic [SAMPLE_W-1:0]   sample_cnt_q;
	logic [LW-1:0]         loaded_q;

	// Accumulators and minimum tracker.
	logic [ACC_W-1:0]      acc_q [MAX_CLUSTERS];
	logic [ACC_W-1:0]      best_q;
	logic [CW-1:0]         best_idx_q;

	// Visit pipeline.
	logic                  v_s1, v_s2;
	logic [CW-1:0]         c_s1, c_s2;
	logic                  byp_s1;
	logic [SQ_W-1:0]       sq_s2;

	// Output register.
	logic                  out_valid_q;
	logic [SAMPLE_W-1:0]   out_sample_q;
	logic [CLUSTER_W-1:0]  out_cluster_q;
	logic                  out_became_q;

	// Clamped configuration and per-item decisions.
	logic [LW-1:0]         k_cfg;
	logic [DW:0]           dims_cfg;
	logic                  becoming;
	logic                  last;
	logic [LW-1:0]         active;

	always_comb begin
		if (num_clusters == '0) begin
			k_cfg = LW'(1);
		end else if (32'(num_clusters) > MAX_CLUSTERS) begin
			k_cfg = LW'(MAX_CLUSTERS);
		end else begin
			k_cfg = LW'(num_clusters);
		end
		if (num_dims == '0) begin
			dims_cfg = (DW + 1)'(1);
		end else if (32'(num_dims) > MAX_DIMS) begin
			dims_cfg = (DW + 1)'(MAX_DIMS);
		end else begin
			dims_cfg = (DW + 1)'(num_dims);
		end
		becoming = (loaded_q < k_cfg);
		active   = becoming ? (loaded_q + LW'(1)) : k_cfg;
		last     = (((DW + 1)'(coord_cnt_q) + (DW + 1)'(1)) >= dims_cfg);
	end

	// Center store: write the new center's coordinate, read one center per visit.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [COORD_BITS-1:0] ram_rdata;

	assign ram_we    = cmd.load && becoming;
	assign ram_waddr = AW'(loaded_q) * AW'(MAX_DIMS) + AW'(coord_cnt_q);
	assign ram_raddr = AW'(cidx) * AW'(MAX_DIMS) + AW'(d_q);

	nca_ram #(
		.WIDTH (COORD_BITS),
		.DEPTH (DEPTH)
	) u_center_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (coord_value),
		.re    (cmd.issue),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Item capture and coordinate counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_cnt_q <= '0;
			last_q      <= 1'b0;
			becoming_q  <= 1'b0;
			active_q    <= LW'(1);
		end else if (cmd.load) begin
			coord_cnt_q <= last ? '0 : (coord_cnt_q + DW'(1));
			last_q      <= last;
			becoming_q  <= becoming;
			active_q    <= active;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= coord_value;
			d_q <= coord_cnt_q;
		end
	end

	// Stage 1: read address issued, note whether the visited center is the new one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		c_s1   <= cidx;
		byp_s1 <= becoming_q && (LW'(cidx) == loaded_q);
	end

	// Stage 2: difference, magnitude and square.
	logic [COORD_BITS-1:0] center;
	logic [COORD_BITS:0]   diff;
	logic [COORD_BITS:0]   mag;

	always_comb begin
		center = byp_s1 ? x_q : ram_rdata;
		diff   = {x_q[COORD_BITS-1], x_q} - {center[COORD_BITS-1], center};
		mag    = diff[COORD_BITS] ? ((COORD_BITS + 1)'(0) - diff) : diff;
	end

	always_ff @(posedge clk) begin
		sq_s2 <= SQ_W'(mag) * SQ_W'(mag);
		c_s2  <= c_s1;
	end

	// Stage 3: accumulate and track the smallest distance, lowest index on ties.
	logic [ACC_W-1:0] acc_new;

	assign acc_new = acc_q[c_s2] + ACC_W'(sq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				acc_q[i] <= '0;
			end
		end else if (cmd.emit) begin
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				acc_q[i] <= '0;
			end
		end else if (v_s2) begin
			acc_q[c_s2] <= acc_new;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && ((c_s2 == '0) || (acc_new < best_q))) begin
			best_q     <= acc_new;
			best_idx_q <= c_s2;
		end
	end

	// Sample counters advance when a result is emitted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_cnt_q <= '0;
			loaded_q     <= '0;
		end else if (cmd.emit) begin
			sample_cnt_q <= sample_cnt_q + SAMPLE_W'(1);
			if (becoming_q) begin
				loaded_q <= loaded_q + LW'(1);
			end
		end
	end

	// Output register holds the result until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_sample_q  <= sample_cnt_q;
			out_cluster_q <= CLUSTER_W'(best_idx_q);
			out_became_q  <= becoming_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign sample_number   = out_sample_q;
	assign nearest_cluster = out_cluster_q;
	assign became_center   = out_became_q;

	// Status toward the controller.
	always_comb begin
		sts.last        = last_q;
		sts.final_visit = (LW'(cidx) == (active_q - LW'(1)));
		sts.busy        = v_s1 || v_s2;
		sts.out_free    = !out_valid_q || out_ready;
	end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the streaming nearest-center assignment block.
`timescale 1ns / 1ps

module tb;
	import nca_pkg::*;

	localparam int ITEM_TOTAL    = 650;
	localparam int CALM_ITEMS    = 80;
	localparam int LOAD_SAMPLES  = 18;
	localparam int SETTLE_CYCLES = 2 * (MAX_CLUSTERS_DEF + 5) + 8;
	localparam int HOLD_AT       = 8;
	localparam int HOLD_CYCLES   = 1500;
	localparam int CYCLE_LIMIT   = 400000;

	// Extreme and patterned coordinates for the first, full-width sample.
	localparam logic [15:0] EDGE_COORDS [16] = '{
		16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h7ffe, 16'h8001, 16'h5555,
		16'haaaa, 16'h00ff, 16'hff00, 16'h4000, 16'hc000, 16'h1234, 16'hedcb, 16'h7fff
	};

	// One finished sample as it leaves the block.
	typedef struct packed {
		logic [31:0] sample_no;
		logic [3:0]  cluster;
		logic        center;
	} assignment_t;

	typedef enum {ROW_READ, ROW_WRITE, ROW_COORD} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [31:0] value;
		bit          typed;
		assignment_t want;
	} plan_row_t;

	typedef enum {PICK_NOISE, PICK_COPY, PICK_NEAR, PICK_EXTREME} coord_pick_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   psel     = 1'b0;
	logic                   penable  = 1'b0;
	logic                   pwrite   = 1'b0;
	logic [2:0]             paddr    = '0;
	logic [31:0]            pwdata   = '0;
	logic [31:0]            prdata;
	logic                   pready;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// s_tdata: [15:0] coord_value
	logic [15:0]            s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b1;
	// m_tdata: [31:0] sample_number, [35:32] nearest_cluster, zero fill above
	logic [OUT_TDATA_W-1:0] m_tdata;
	// m_tuser: [0] became_center
	logic                   m_tuser;

	// Shadow of the block: registers, center store, running sums and counters.
	logic [4:0]           cfg_clusters = NUM_CLUSTERS_RESET;
	logic [4:0]           cfg_dims     = NUM_DIMS_RESET;
	logic signed [15:0]   centers [MAX_CLUSTERS_DEF][MAX_DIMS_DEF];
	longint unsigned      dist_acc [MAX_CLUSTERS_DEF];
	int unsigned          coord_pos    = 0;
	logic [31:0]          sample_count = '0;
	int unsigned          loaded       = 0;

	assignment_t expected_assignments [$];
	plan_row_t   plan [$];
	int          mismatches   = 0;
	int          items_sent   = 0;
	int          results_seen = 0;
	int          cycle_count  = 0;
	bit          calm         = 1'b0;
	coord_pick_t pick_mode    = PICK_NOISE;
	int unsigned pick_center  = 0;

	nearest_center_assign u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A register value of 0 acts as 1, anything above the maximum as the maximum.
	function automatic int unsigned effective(input logic [4:0] v, input int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// Folds one coordinate into the running distances; returns 1 when the sample ends.
	function automatic bit assign_coordinate(input logic [15:0] raw, output assignment_t res);
		int unsigned     k;
		int unsigned     dims;
		int unsigned     active;
		int unsigned     best;
		bit              becoming;
		longint          x;
		longint          diff;
		longint unsigned mag;
		longint unsigned best_dist;
		k = effective(cfg_clusters, MAX_CLUSTERS_DEF);
		dims = effective(cfg_dims, MAX_DIMS_DEF);
		x = $signed(raw);
		becoming = loaded < k;
		active = becoming ? loaded + 1 : k;
		res = '0;
		if (becoming)
			centers[loaded][coord_pos] = raw;
		for (int unsigned c = 0; c < active; c++) begin
			diff = x - longint'(centers[c][coord_pos]);
			mag = (diff < 0) ? -diff : diff;
			dist_acc[c] += mag * mag;
		end
		if (coord_pos + 1 < dims) begin
			coord_pos++;
			return 1'b0;
		end
		// Sample complete: strict compare keeps the lowest index on ties.
		best = 0;
		best_dist = dist_acc[0];
		for (int unsigned c = 1; c < active; c++) begin
			if (dist_acc[c] < best_dist) begin
				best_dist = dist_acc[c];
				best = c;
			end
		end
		res.sample_no = sample_count;
		res.cluster = best[3:0];
		res.center = becoming;
		foreach (dist_acc[c])
			dist_acc[c] = 0;
		coord_pos = 0;
		sample_count++;
		if (becoming)
			loaded++;
		return 1'b1;
	endfunction

	// Chooses the next coordinate; each sample follows one pattern picked at its start.
	function automatic logic [15:0] next_coordinate();
		if (coord_pos == 0) begin
			pick_mode = coord_pick_t'($urandom_range(0, 3));
			pick_center = (loaded == 0) ? 0 : $urandom_range(0, loaded - 1);
			if (loaded == 0 && (pick_mode == PICK_COPY || pick_mode == PICK_NEAR))
				pick_mode = PICK_NOISE;
		end
		case (pick_mode)
			PICK_COPY: return centers[pick_center][coord_pos];
			PICK_NEAR: return centers[pick_center][coord_pos] + 16'($urandom_range(0, 32)) - 16'd16;
			PICK_EXTREME: begin
				case ($urandom_range(0, 4))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					3: return 16'hffff;
					default: return 16'h0001;
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	// Register setting for a random phase, out-of-range values and upper bits included.
	function automatic logic [31:0] random_setting();
		logic [4:0] raw;
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 4))
				0: raw = 5'd0;
				1: raw = 5'd1;
				2: raw = 5'd16;
				3: raw = 5'd17;
				default: raw = 5'd31;
			endcase
		end else begin
			raw = 5'($urandom_range(1, 16));
		end
		return ($urandom & ~32'h1f) | 32'(raw);
	endfunction

	function automatic plan_row_t reg_row(input row_kind_t kind, input reg_idx_t idx,
			input logic [31:0] value);
		return '{kind: kind, idx: idx, value: value, typed: 1'b0, want: '0};
	endfunction

	function automatic plan_row_t coord_row(input logic [15:0] value, input bit typed,
			input assignment_t want);
		return '{kind: ROW_COORD, idx: REG_NUM_CLUSTERS, value: 32'(value), typed: typed,
			want: want};
	endfunction

	// Register write: setup cycle, then access cycle.
	task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_NUM_CLUSTERS)
			cfg_clusters = value[4:0];
		else
			cfg_dims = value[4:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_register(input reg_idx_t idx, output logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one coordinate, sometimes after a gap, and predicts on acceptance.
	task automatic drive_coordinate(input logic [15:0] value, input bit typed,
			input assignment_t want);
		assignment_t predicted;
		int          gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (items_sent >= ITEM_TOTAL - CALM_ITEMS)
			calm = 1'b1;
		if (assign_coordinate(value, predicted))
			expected_assignments.insert(expected_assignments.size(),
				typed ? want : predicted);
	endtask

	// Drains every expected result and lets the last coordinate finish its visits.
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (expected_assignments.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Output side: checks each transaction and throttles m_tready.
	always @(posedge clk) begin : result_monitor
		assignment_t got;
		assignment_t want;
		static int hold_left  = 0;
		static int stall_left = 0;
		static bit hold_done  = 1'b0;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{sample_no: m_tdata[31:0], cluster: m_tdata[35:32], center: m_tuser};
			results_seen++;
			if (expected_assignments.size() == 0) begin
				$error("unexpected result: sample_number %0d", got.sample_no);
				mismatches++;
			end else begin
				want = expected_assignments.pop_front();
				if (got.sample_no != want.sample_no) begin
					$error("sample_number: expected %0d, actual %0d",
						want.sample_no, got.sample_no);
					mismatches++;
				end
				if (got.cluster != want.cluster) begin
					$error("nearest_cluster: expected %0d, actual %0d",
						want.cluster, got.cluster);
					mismatches++;
				end
				if (got.center != want.center) begin
					$error("became_center: expected %0d, actual %0d", want.center, got.center);
					mismatches++;
				end
			end
		end
		// One long hold-off fills the block so that it stalls its input.
		if (hold_left > 0) begin
			hold_left--;
		end else if (!hold_done && results_seen >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end else if (stall_left > 0) begin
			stall_left--;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 7);
		end
		m_tready <= (hold_left == 0 && stall_left == 0);
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] rd;
		int          n;
		foreach (centers[c, d])
			centers[c][d] = '0;
		foreach (dist_acc[c])
			dist_acc[c] = 0;

		// Directed rows: reset values, out-of-range settings, the first center.
		plan.insert(plan.size(), reg_row(ROW_READ, REG_NUM_CLUSTERS, 32'(NUM_CLUSTERS_RESET)));
		plan.insert(plan.size(), reg_row(ROW_READ, REG_NUM_DIMS, 32'(NUM_DIMS_RESET)));
		plan.insert(plan.size(), reg_row(ROW_WRITE, REG_NUM_CLUSTERS, 32'd0));
		plan.insert(plan.size(), reg_row(ROW_WRITE, REG_NUM_DIMS, 32'd31));
		plan.insert(plan.size(), reg_row(ROW_READ, REG_NUM_DIMS, 32'd31));
		foreach (EDGE_COORDS[i])
			plan.insert(plan.size(),
				coord_row(EDGE_COORDS[i], i == 15, assignment_t'{32'd0, 4'd0, 1'b1}));
		// One coordinate per sample, a single center: always cluster 0, no new center.
		plan.insert(plan.size(), reg_row(ROW_WRITE, REG_NUM_DIMS, 32'd0));
		plan.insert(plan.size(), coord_row(16'h7fff, 1'b1, assignment_t'{32'd1, 4'd0, 1'b0}));
		plan.insert(plan.size(), coord_row(16'h8000, 1'b1, assignment_t'{32'd2, 4'd0, 1'b0}));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_READ: begin
					wait_quiet();
					read_register(plan[i].idx, rd);
					if (rd[CFG_W-1:0] != plan[i].value[CFG_W-1:0]) begin
						$error("prdata: expected %0d, actual %0d",
							plan[i].value[CFG_W-1:0], rd[CFG_W-1:0]);
						mismatches++;
					end
				end
				ROW_WRITE: begin
					wait_quiet();
					write_register(plan[i].idx, plan[i].value);
				end
				default: drive_coordinate(plan[i].value[15:0], plan[i].typed, plan[i].want);
			endcase
		end

		// Load every center at full width so any later sample length stays legal.
		wait_quiet();
		write_register(REG_NUM_CLUSTERS, 32'd16);
		write_register(REG_NUM_DIMS, 32'd16);
		repeat (LOAD_SAMPLES * MAX_DIMS_DEF)
			drive_coordinate(next_coordinate(), 1'b0, '0);

		// Random phases; a phase may end mid-sample, so sample lengths change on the fly.
		while (items_sent < ITEM_TOTAL) begin
			wait_quiet();
			write_register(REG_NUM_CLUSTERS, random_setting());
			write_register(REG_NUM_DIMS, random_setting());
			n = $urandom_range(12, 48);
			repeat (n)
				drive_coordinate(next_coordinate(), 1'b0, '0);
		end

		wait_quiet();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
